### rtl/core/stkba_pkg.sv
// stkba_pkg: shared types and constants of the stack block allocator
// request and response payload structs, configuration register indexes, reset values
// no dependencies
package stkba_pkg;

    localparam int ADDR_W = 27;
    localparam int MAXB_W = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS  = 3'd3;

    localparam logic [ADDR_W-1:0] RST_REGION_BASE = 27'd16384;
    localparam logic [ADDR_W-1:0] RST_REGION_SIZE = 27'd16777216;
    localparam logic [MAXB_W-1:0] RST_MAX_BLOCKS  = 7'd64;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] request_length;
    } t_req;

    typedef struct packed {
        logic              accepted;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] freed_length;
    } t_rsp;

endpackage

### rtl/core/stkba_align.sv
// stkba_align: tests whether a length is a multiple of the alignment
// power-of-two part by a mask, odd part by a modular-inverse multiply; uses stkba_pkg
module stkba_align #(
    parameter int ALIGN_BYTES = 32
) (
    input  logic [stkba_pkg::ADDR_W-1:0] i_len,
    output logic                         o_aligned
);
    import stkba_pkg::*;

    function automatic int ctz(input int v);
        int n;
        n = 0;
        for (int b = 0; b < 13; b++) begin
            if (((v >> b) & 1) == 0 && n == b) n = b + 1;
        end
        return n;
    endfunction

    // newton iteration for the inverse of an odd number mod 2^32
    function automatic logic [31:0] modinv(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int i = 0; i < 5; i++) x = x * (32'd2 - a * x);
        return x;
    endfunction

    localparam int TZ = ctz(ALIGN_BYTES);
    localparam int ODD = ALIGN_BYTES >> TZ;
    localparam logic [31:0] INV = modinv(ODD);
    localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((1 << TZ) - 1);
    localparam logic [ADDR_W-1:0] LIMIT = ADDR_W'(((1 << ADDR_W) - 1) / ODD);

    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] prod;

    // n is a multiple of odd d iff n * inv(d) mod 2^w <= (2^w - 1) / d
    assign shifted   = i_len >> TZ;
    assign prod      = ADDR_W'(shifted * INV[ADDR_W-1:0]);
    assign o_aligned = ((i_len & LOW_MASK) == '0) && (prod <= LIMIT);

endmodule

### rtl/core/stack_block_allocator_core.sv
// Stack block allocator: LIFO region allocator with a length table, one request per cycle unless the receiver stalls.
// Request and response ports use valid/stall. Config port uses valid/ready.
// Usage:
//   Request channel: i_in_valid/o_in_stall with a t_req payload (kind 0 allocate,
//   kind 1 free newest block). Response channel: o_out_valid/i_out_stall with a t_rsp
//   payload; every request gives exactly one response, in order.
//   Config channel: i_cfg_valid/o_cfg_ready with a register index and data, always
//   ready; write only while no request is in flight.
//   A taken request is held in the request register, where it is checked, and its
//   response is registered in the response register. Throughput is one request per cycle
//   while the receiver does not stall, set by the single check/update pass between them.
//   The length table is a memory with a registered read that tracks the entry below
//   the top; the top entry sits in a register, so back-to-back frees need no stall.
//   Reset loads the register defaults, puts the stack top at the base and empties
//   the table; the table memory itself is not cleared.
//   When the receiver stalls, the response register holds and the request register
//   fills, after which o_in_stall rises.
module stack_block_allocator_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int ALIGN_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  stkba_pkg::t_req                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output stkba_pkg::t_rsp                 o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stkba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stkba_pkg::ADDR_W-1:0]    i_cfg_data
);
    import stkba_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW = (CW > MAXB_W) ? CW : MAXB_W;

    logic              r_enabled;
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_size;
    logic [MAXB_W-1:0] r_max_blocks;

    logic              r_in_valid;
    t_req              r_in;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [ADDR_W-1:0] r_stack_top;
    logic [CW-1:0]     r_count;
    logic [ADDR_W-1:0] r_top_len;
    logic [ADDR_W-1:0] r_second;
    logic [ADDR_W-1:0] r_mem [TABLE_DEPTH];

    logic              n_ok_alloc;
    logic              n_ok_free;
    logic [CW-1:0]     n_count;
    t_rsp              n_rsp;
    logic              fire;
    logic              len_aligned;
    logic [AW-1:0]     rd_addr;
    logic [MW-1:0]     count_ext;
    logic [MW-1:0]     maxb_ext;

    stkba_align #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_align (
        .i_len     (r_in.request_length),
        .o_aligned (len_aligned)
    );

    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign count_ext = MW'(r_count);
    assign maxb_ext  = MW'(r_max_blocks);

    always_comb begin
        n_ok_alloc = r_enabled && len_aligned
                     && (count_ext < maxb_ext)
                     && (r_count < CW'(TABLE_DEPTH))
                     && (r_stack_top >= r_region_base)
                     && (r_stack_top <= r_region_size)
                     && (r_in.request_length <= r_region_size - r_stack_top);
        // stored lengths were aligned when pushed, so no alignment test here
        n_ok_free  = r_enabled && (r_count != '0)
                     && (r_stack_top >= r_region_base)
                     && (r_top_len <= r_stack_top - r_region_base);

        n_rsp   = '0;
        n_count = r_count;
        if (r_in.kind == KIND_ALLOC) begin
            if (n_ok_alloc) begin
                n_rsp.accepted = 1'b1;
                n_rsp.address  = r_stack_top;
                if (fire) n_count = r_count + CW'(1);
            end
        end else begin
            if (n_ok_free) begin
                n_rsp.accepted     = 1'b1;
                n_rsp.address      = r_stack_top - r_top_len;
                n_rsp.freed_length = r_top_len;
                if (fire) n_count = r_count - CW'(1);
            end
        end
    end

    // the entry below the new top is read every cycle so a pop can refill r_top_len
    assign rd_addr = AW'(n_count - CW'(2));

    always_ff @(posedge i_clk) begin
        if (fire && r_in.kind == KIND_ALLOC && n_ok_alloc) begin
            r_mem[r_count[AW-1:0]] <= r_in.request_length;
        end
        r_second <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b1;
            r_region_base <= RST_REGION_BASE;
            r_region_size <= RST_REGION_SIZE;
            r_max_blocks  <= RST_MAX_BLOCKS;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_stack_top   <= RST_REGION_BASE;
            r_count       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLED:     r_enabled     <= i_cfg_data[0];
                    CFG_REGION_BASE: r_region_base <= i_cfg_data;
                    CFG_REGION_SIZE: r_region_size <= i_cfg_data;
                    CFG_MAX_BLOCKS:  r_max_blocks  <= i_cfg_data[MAXB_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_count <= n_count;
            if (fire && r_in.kind == KIND_ALLOC && n_ok_alloc) begin
                r_stack_top <= r_stack_top + r_in.request_length;
            end else if (fire && r_in.kind == KIND_FREE && n_ok_free) begin
                r_stack_top <= r_stack_top - r_top_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_rsp;
        end
        if (fire && r_in.kind == KIND_ALLOC && n_ok_alloc) begin
            r_top_len <= r_in.request_length;
        end else if (fire && r_in.kind == KIND_FREE && n_ok_free) begin
            r_top_len <= r_second;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("block count beyond table depth");

    a_alloc_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.kind == KIND_ALLOC && n_ok_alloc |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted allocate did not push");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.accepted |-> r_out.address == '0 && r_out.freed_length == '0)
        else $error("rejected response carries data");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("request stalled without backpressure");

    a_free_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.kind == KIND_FREE && n_ok_free |=> r_stack_top == $past(n_rsp.address))
        else $error("free moved top to wrong address");
`endif

endmodule

### test/stack_block_allocator_checker.sv
// stack_block_allocator_checker: watches the request, response and register channels of the
// stack block allocator, predicts every response and compares it field by field
// depends on stkba_pkg
module stack_block_allocator_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int ALIGN_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  stkba_pkg::t_req                 i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  stkba_pkg::t_rsp                 i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [stkba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stkba_pkg::ADDR_W-1:0]    i_cfg_data,
    output int                              o_failures,
    output int                              o_pending,
    output int                              o_allocs_granted,
    output int                              o_frees_granted,
    output int                              o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    import stkba_pkg::*;

    // register copies
    logic              en_q;
    logic [ADDR_W-1:0] base_q;
    logic [ADDR_W-1:0] size_q;
    logic [MAXB_W-1:0] maxb_q;

    // allocator state
    logic [ADDR_W-1:0] top_q;
    int                live_blocks;
    logic [ADDR_W-1:0] len_table [TABLE_DEPTH];

    t_rsp owed_q [$];
    int   fail_count = 0;
    int   allocs_granted = 0;
    int   frees_granted = 0;
    int   rejected = 0;

    assign o_failures       = fail_count;
    assign o_allocs_granted = allocs_granted;
    assign o_frees_granted  = frees_granted;
    assign o_rejected       = rejected;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        if (fail_count < 100) begin
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // applies one request to the allocator state and returns the response it owes
    function automatic t_rsp serve_request(input t_req req);
        t_rsp              rsp;
        logic [ADDR_W-1:0] popped;
        rsp = '0;
        if (req.kind == KIND_ALLOC) begin
            if (en_q && (req.request_length % ALIGN_BYTES) == 0 &&
                live_blocks < int'(maxb_q) && live_blocks < TABLE_DEPTH &&
                top_q >= base_q && top_q <= size_q &&
                req.request_length <= size_q - top_q) begin
                rsp.accepted = 1'b1;
                rsp.address = top_q;
                len_table[live_blocks] = req.request_length;
                top_q = top_q + req.request_length;
                live_blocks++;
            end
        end else if (en_q && live_blocks != 0) begin
            popped = len_table[live_blocks - 1];
            // registers may have moved the base above the stack since the push
            if ((popped % ALIGN_BYTES) == 0 && top_q >= base_q && popped <= top_q - base_q) begin
                live_blocks--;
                top_q = top_q - popped;
                rsp.accepted = 1'b1;
                rsp.address = top_q;
                rsp.freed_length = popped;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            en_q = 1'b1;
            base_q = RST_REGION_BASE;
            size_q = RST_REGION_SIZE;
            maxb_q = RST_MAX_BLOCKS;
            top_q = RST_REGION_BASE;
            live_blocks = 0;
            owed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLED:     en_q = i_cfg_data[0];
                    CFG_REGION_BASE: base_q = i_cfg_data;
                    CFG_REGION_SIZE: size_q = i_cfg_data;
                    CFG_MAX_BLOCKS:  maxb_q = i_cfg_data[MAXB_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                want = serve_request(i_in_data);
                if (!want.accepted) begin
                    rejected++;
                end else if (i_in_data.kind == KIND_ALLOC) begin
                    allocs_granted++;
                end else begin
                    frees_granted++;
                end
                owed_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (owed_q.size() == 0) begin
                    report_mismatch("response with none owed", got.address, '0);
                end else begin
                    want = owed_q.pop_front();
                    if (got.accepted !== want.accepted) begin
                        report_mismatch("accepted", ADDR_W'(got.accepted),
                                        ADDR_W'(want.accepted));
                    end
                    if (got.address !== want.address) begin
                        report_mismatch("address", got.address, want.address);
                    end
                    if (got.freed_length !== want.freed_length) begin
                        report_mismatch("freed_length", got.freed_length, want.freed_length);
                    end
                end
            end
        end
        o_pending <= owed_q.size();
    end

endmodule

### test/stack_block_allocator_core_tb.sv
// stack_block_allocator_core_tb: drives requests and register writes into the allocator
// with random idling on both sides and gives the verdict
// depends on stkba_pkg, stack_block_allocator_core and stack_block_allocator_checker
module stack_block_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stkba_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int ALIGN_BYTES = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_req              in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_rsp              out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0] cfg_data = '0;

    logic idle_on = 1'b1;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   sent = 0;
    int   settings_written = 0;

    int failures;
    int pending;
    int allocs_granted;
    int frees_granted;
    int rejected;

    stack_block_allocator_core #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ALIGN_BYTES(ALIGN_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    stack_block_allocator_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_allocs_granted(allocs_granted),
        .o_frees_granted (frees_granted),
        .o_rejected      (rejected)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // receiver stalls in random bursts while idling is on
    always @(posedge clk) begin
        if (!rst_n || !idle_on) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid is not lowered after the request is taken; a gap lowers it before the next request goes out
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] len);
        t_req req;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req.kind = kind;
        req.request_length = len;
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // only bit 0 of the enable word and the low bits of the block limit count
    task automatic set_config(input logic [ADDR_W-1:0] en_word, input logic [ADDR_W-1:0] base,
                              input logic [ADDR_W-1:0] size, input logic [ADDR_W-1:0] maxb);
        write_register(CFG_IDX_W'($urandom_range(CFG_MAX_BLOCKS + 1, (1 << CFG_IDX_W) - 1)),
                       ADDR_W'($urandom));
        write_register(CFG_ENABLED, en_word);
        write_register(CFG_REGION_BASE, base);
        write_register(CFG_REGION_SIZE, size);
        write_register(CFG_MAX_BLOCKS, maxb);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_length(input int big_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < big_pct) begin
            return ADDR_W'($urandom) & ~ADDR_W'(ALIGN_BYTES - 1);
        end else if (roll < big_pct + 6) begin
            return ADDR_W'($urandom);
        end else if (roll < big_pct + 12) begin
            return ADDR_W'(ALIGN_BYTES * $urandom_range(0, 8) + $urandom_range(1, ALIGN_BYTES - 1));
        end
        return ADDR_W'(ALIGN_BYTES * $urandom_range(0, 64));
    endfunction

    task automatic run_requests(input int count, input int alloc_pct, input int big_pct);
        logic kind;
        for (int k = 0; k < count; k++) begin
            kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
            if (kind == KIND_ALLOC) begin
                send_request(kind, pick_length(big_pct));
            end else begin
                send_request(kind, ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty stack at the base
        send_request(KIND_FREE, '0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, '0);
        send_request(KIND_ALLOC, ADDR_W'(1));
        send_request(KIND_ALLOC, ADDR_W'(ALIGN_BYTES));
        send_request(KIND_ALLOC, ~ADDR_W'(ALIGN_BYTES - 1));
        send_request(KIND_ALLOC, '1);
        // fill memory exactly to its size, then a zero length at the very top
        send_request(KIND_ALLOC, RST_REGION_SIZE - RST_REGION_BASE - ADDR_W'(ALIGN_BYTES));
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, ADDR_W'(ALIGN_BYTES));
        send_request(KIND_ALLOC, ADDR_W'(ALIGN_BYTES / 2));
        send_request(KIND_FREE, '1);
        send_request(KIND_FREE, '0);
        send_request(KIND_FREE, '0);
        send_request(KIND_FREE, '0);
        send_request(KIND_ALLOC, ADDR_W'(ALIGN_BYTES * 3));
        run_requests(200, 60, 2);
        wait_for_drain();

        // no usable table entries: allocations fail, frees still pop
        set_config(ADDR_W'(1), RST_REGION_BASE, RST_REGION_SIZE, '0);
        run_requests(40, 50, 2);
        wait_for_drain();

        // block limit above the table depth
        set_config(ADDR_W'(1), RST_REGION_BASE, RST_REGION_SIZE, '1);
        run_requests(120, 70, 2);
        wait_for_drain();

        set_config(ADDR_W'(1), RST_REGION_BASE, RST_REGION_SIZE, ADDR_W'(3));
        run_requests(100, 55, 2);
        wait_for_drain();

        // disabled: enable word with bit 0 clear
        set_config(ADDR_W'(27'h7FFFFFE), RST_REGION_BASE, RST_REGION_SIZE, ADDR_W'(RST_MAX_BLOCKS));
        run_requests(40, 50, 2);
        wait_for_drain();

        // base moved above the current top
        set_config(ADDR_W'(1), '1, RST_REGION_SIZE, ADDR_W'(RST_MAX_BLOCKS));
        run_requests(40, 50, 2);
        wait_for_drain();

        // zero size leaves the top beyond it
        set_config(ADDR_W'(1), '0, '0, ADDR_W'(RST_MAX_BLOCKS));
        run_requests(60, 30, 2);
        wait_for_drain();

        // full address range with large lengths
        set_config(ADDR_W'(1), '0, '1, ADDR_W'(RST_MAX_BLOCKS));
        run_requests(150, 55, 25);
        wait_for_drain();

        set_config(ADDR_W'(27'h2AAAAAB), ADDR_W'(27'h4000000), ADDR_W'(27'h4000000),
                   ADDR_W'(RST_MAX_BLOCKS));
        run_requests(40, 50, 10);
        wait_for_drain();

        set_config(ADDR_W'(1), RST_REGION_BASE, RST_REGION_SIZE, ADDR_W'(RST_MAX_BLOCKS));
        run_requests(150, 50, 3);
        wait_for_drain();
        run_requests(150, 50, 3);
        wait_for_drain();

        // last stretch without idling on either side
        set_config(ADDR_W'(1), ADDR_W'(ALIGN_BYTES), ADDR_W'(27'h0100000), ADDR_W'(16));
        idle_on <= 1'b0;
        run_requests(100, 55, 2);
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("%0d requests over %0d register settings: %0d allocations and %0d frees granted",
                 sent, settings_written + 1, allocs_granted, frees_granted);
        $display("%0d requests rejected (disabled, misaligned, full table, bounds, empty stack)",
                 rejected);
        if (failures == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
